[rtl/bds_pkg.sv]
package bds_pkg;

	localparam int MaxWidth    = 4096;
	localparam int HeightLimit = 4096;
	localparam int LineDepth   = MaxWidth / 2;
	localparam int SlotW       = $clog2(LineDepth);
	localparam int CountW      = 12;
	localparam int DimW        = 13;
	localparam int PixW        = 8;
	localparam int PairW       = PixW + 1;
	localparam int TotalW      = PixW + 2;
	localparam int CfgIdxW     = 1;

	localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'b0;
	localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

	localparam logic [DimW-1:0] WidthReset  = 13'd640;
	localparam logic [DimW-1:0] HeightReset = 13'd480;
	localparam logic [DimW-1:0] DimMin      = 13'd2;
	localparam logic [DimW-1:0] WidthMax    = DimW'(MaxWidth);
	localparam logic [DimW-1:0] HeightMax   = DimW'(HeightLimit);

	typedef struct packed {
		logic             x_odd;
		logic             y_odd;
		logic [SlotW-1:0] slot;
		logic             last;
	} pos_t;

	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
		input logic [DimW-1:0] hi);
		logic [DimW-1:0] r;
		if (v < DimMin) begin
			r = DimMin;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[rtl/bds_pix_if.sv]
interface bds_pix_if;
	logic                      valid;
	logic                      ready;
	logic [bds_pkg::PixW-1:0]  pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

[rtl/bds_out_if.sv]
interface bds_out_if;
	logic                      valid;
	logic                      ready;
	logic [bds_pkg::PixW-1:0]  pixel_out;
	logic                      end_of_frame;

	modport source (output valid, output pixel_out, output end_of_frame, input ready);
	modport sink (input valid, input pixel_out, input end_of_frame, output ready);
endinterface

[rtl/bds_line_buf.sv]
module bds_line_buf (
	input  logic                        clk,
	input  logic                        we,
	input  logic [bds_pkg::SlotW-1:0]   waddr,
	input  logic [bds_pkg::PairW-1:0]   wdata,
	input  logic                        re,
	input  logic [bds_pkg::SlotW-1:0]   raddr,
	output logic [bds_pkg::PairW-1:0]   rdata
);

	logic [bds_pkg::PairW-1:0] mem [bds_pkg::LineDepth];
	logic [bds_pkg::PairW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/bds_pos.sv]
module bds_pos (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bds_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bds_pkg::DimW-1:0]     cfg_data,
	input  logic                         advance,
	output bds_pkg::pos_t                pos
);

	logic [bds_pkg::DimW-1:0]   width_q;
	logic [bds_pkg::DimW-1:0]   height_q;
	logic [bds_pkg::CountW-1:0] col_q;
	logic [bds_pkg::CountW-1:0] row_q;
	logic [bds_pkg::DimW-1:0]   col_inc;
	logic [bds_pkg::DimW-1:0]   row_inc;
	logic [bds_pkg::DimW-1:0]   last_x_full;
	logic [bds_pkg::DimW-1:0]   last_y_full;

	// clamped dimensions are kept, so the datapath never sees out of range values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bds_pkg::WidthReset;
			height_q <= bds_pkg::HeightReset;
		end else if (cfg_we) begin
			case (cfg_index)
				bds_pkg::RegImageWidth: begin
					width_q <= bds_pkg::clamp_dim(cfg_data, bds_pkg::WidthMax);
				end
				bds_pkg::RegImageHeight: begin
					height_q <= bds_pkg::clamp_dim(cfg_data, bds_pkg::HeightMax);
				end
				default: begin
				end
			endcase
		end
	end

	assign col_inc = {1'b0, col_q} + bds_pkg::DimW'(1);
	assign row_inc = {1'b0, row_q} + bds_pkg::DimW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_inc >= width_q) begin
				col_q <= '0;
				row_q <= (row_inc >= height_q) ? '0 : row_inc[bds_pkg::CountW-1:0];
			end else begin
				col_q <= col_inc[bds_pkg::CountW-1:0];
				if ({1'b0, row_q} >= height_q) begin
					row_q <= '0;
				end
			end
		end
	end

	assign last_x_full = {width_q[bds_pkg::DimW-1:1], 1'b0} - bds_pkg::DimW'(1);
	assign last_y_full = {height_q[bds_pkg::DimW-1:1], 1'b0} - bds_pkg::DimW'(1);

	assign pos.x_odd = col_q[0];
	assign pos.y_odd = row_q[0];
	assign pos.slot  = bds_pkg::SlotW'(col_q >> 1);
	assign pos.last  = (col_q == last_x_full[bds_pkg::CountW-1:0])
		&& (row_q == last_y_full[bds_pkg::CountW-1:0]);

endmodule

[rtl/box_downsample_2x2.sv]
// channel   dir  payload                    handshake
// pixels    in   pixel_in[7:0]              valid/ready
// blocks    out  pixel_out[7:0], end_of_frame  valid/ready
// cfg       in   cfg_index, cfg_data[12:0]  cfg_we, no back-pressure
//
// one pixel per clock unless stalled; odd row, odd column pixel loads result register
// line buffer read issued on each even column, data used on odd columns of odd rows
// arst_n clears counters and output valid, dimensions return to 640 x 480
// pixels stall only while the output register holds a result not taken
module box_downsample_2x2 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bds_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bds_pkg::DimW-1:0]     cfg_data,
	bds_pix_if.sink                      pixels,
	bds_out_if.source                    blocks
);

	bds_pkg::pos_t              pos;
	logic                       accept;
	logic                       rd_en;
	logic                       wr_en;
	logic                       emit;
	logic [bds_pkg::PixW-1:0]   pair_q;
	logic [bds_pkg::PairW-1:0]  pair;
	logic [bds_pkg::PairW-1:0]  line_rdata;
	logic [bds_pkg::TotalW-1:0] total;
	logic                       out_valid_q;
	logic [bds_pkg::PixW-1:0]   out_pixel_q;
	logic                       out_eof_q;

	assign pixels.ready = !out_valid_q || blocks.ready;
	assign accept       = pixels.valid && pixels.ready;

	bds_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.pos       (pos)
	);

	assign rd_en = accept && !pos.x_odd;
	assign wr_en = accept && pos.x_odd && !pos.y_odd;
	assign emit  = accept && pos.x_odd && pos.y_odd;

	assign pair  = {1'b0, pair_q} + {1'b0, pixels.pixel_in};
	assign total = {1'b0, line_rdata} + {1'b0, pair};

	bds_line_buf u_line_buf (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pos.slot),
		.wdata (pair),
		.re    (rd_en),
		.raddr (pos.slot),
		.rdata (line_rdata)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pair_q <= pixels.pixel_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (blocks.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pixel_q <= total[bds_pkg::TotalW-1:2];
			out_eof_q   <= pos.last;
		end
	end

	assign blocks.valid        = out_valid_q;
	assign blocks.pixel_out    = out_pixel_q;
	assign blocks.end_of_frame = out_eof_q;

`ifndef SYNTHESIS
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result transaction not loaded into output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !blocks.ready) |-> !accept)
		else $error("pixel accepted while result held");

	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("line buffer read and write in one cycle");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !blocks.ready) |=> $stable(out_pixel_q) && $stable(out_eof_q))
		else $error("held result changed");
`endif

endmodule
